>>> rtl/fasu_pkg.sv
// Shared constants and types of the floating-point add/subtract unit.
package fasu_pkg;

	localparam int EXP_WIDTH = 11;
	localparam int FRAC_BITS = 52;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_UNF = 2'd2
	} status_t;

	// Load enables of the normalize stages
	typedef struct packed {
		logic load_s4;
		logic load_s5;
	} norm_ctrl_t;

endpackage

>>> rtl/fasu_norm.sv
// Normalize stages: carry renormalize, leading-zero count, left shift, exponent fix.
module fasu_norm #(
	parameter int EXP_WIDTH = fasu_pkg::EXP_WIDTH,
	parameter int FRAC_BITS = fasu_pkg::FRAC_BITS
) (
	input  logic                   clk,
	input  fasu_pkg::norm_ctrl_t   ctrl,
	input  logic [FRAC_BITS+1:0]   m3_s3,
	input  logic [EXP_WIDTH-1:0]   e3_s3,
	input  logic                   sign_s3,
	input  logic                   pass_s3,
	input  logic                   sub_s3,
	output logic                   res_sign,
	output logic [EXP_WIDTH-1:0]   res_exp,
	output logic [FRAC_BITS:0]     res_mant,
	output logic [1:0]             res_status
);

	localparam int MW = FRAC_BITS + 1;
	localparam int KW = $clog2(MW + 1);
	localparam int DW = ((EXP_WIDTH > KW) ? EXP_WIDTH : KW) + 1;

	// stage 4
	logic                 carry;
	logic [MW-1:0]        m4_next;
	logic [EXP_WIDTH-1:0] e4_next;
	logic [KW-1:0]        k_next;

	logic [MW-1:0]        m4_s4;
	logic [EXP_WIDTH-1:0] e4_s4;
	logic [KW-1:0]        k_s4;
	logic                 ovf_s4;
	logic                 sign_s4;
	logic                 pass_s4;
	logic                 sub_s4;

	always_comb begin
		carry   = !pass_s3 && !sub_s3 && m3_s3[MW];
		m4_next = carry ? m3_s3[MW:1] : m3_s3[MW-1:0];
		e4_next = carry ? e3_s3 + 1'b1 : e3_s3;
		// highest set bit wins
		k_next = KW'(MW);
		for (int i = 0; i < MW; i++) begin
			if (m3_s3[i]) begin
				k_next = KW'(MW - 1 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s4) begin
			m4_s4   <= m4_next;
			e4_s4   <= e4_next;
			k_s4    <= k_next;
			ovf_s4  <= carry && (&e3_s3);
			sign_s4 <= sign_s3;
			pass_s4 <= pass_s3;
			sub_s4  <= sub_s3;
		end
	end

	// stage 5
	logic                 shift_en;
	logic                 is_zero;
	logic [DW-1:0]        e_diff;
	logic                 unf;
	logic [MW-1:0]        m5_next;
	logic [EXP_WIDTH-1:0] e5_next;
	logic                 s5_next;
	fasu_pkg::status_t    st5_next;

	logic                 sign_s5;
	logic [EXP_WIDTH-1:0] e_s5;
	logic [MW-1:0]        m_s5;
	fasu_pkg::status_t    st_s5;

	always_comb begin
		shift_en = sub_s4 && !pass_s4;
		is_zero  = !pass_s4 && (m4_s4 == '0);
		e_diff   = DW'(e4_s4) - DW'(k_s4);
		unf      = shift_en && (DW'(k_s4) > DW'(e4_s4));
		m5_next  = shift_en ? (m4_s4 << k_s4) : m4_s4;
		e5_next  = shift_en ? e_diff[EXP_WIDTH-1:0] : e4_s4;
		s5_next  = sign_s4;
		if (ovf_s4) begin
			st5_next = fasu_pkg::ST_OVF;
		end else if (unf) begin
			st5_next = fasu_pkg::ST_UNF;
		end else begin
			st5_next = fasu_pkg::ST_OK;
		end
		// an exact zero sum or difference reads as +0 with exponent 0; a passed-through operand is kept as it is
		if (is_zero) begin
			s5_next  = 1'b0;
			e5_next  = '0;
			st5_next = fasu_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s5) begin
			sign_s5 <= s5_next;
			e_s5    <= e5_next;
			m_s5    <= m5_next;
			st_s5   <= st5_next;
		end
	end

	assign res_sign   = sign_s5;
	assign res_exp    = e_s5;
	assign res_mant   = m_s5;
	assign res_status = st_s5;

endmodule

>>> rtl/float_add_sub_unit.sv
// Top level of the pipelined floating-point add/subtract unit.
// Throughput: one operation per cycle while the output is not stalled; five register
// stages (exponent compare, alignment shift, add/subtract, leading-zero count,
// normalize shift).
// A stall on the output holds only the stages that are full; bubbles still advance.
// Reset clears the stage valid bits only; payload registers are not reset.
module float_add_sub_unit #(
	parameter int EXP_WIDTH = fasu_pkg::EXP_WIDTH,
	parameter int FRAC_BITS = fasu_pkg::FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic                 a_sign,
	input  logic [EXP_WIDTH-1:0] a_exp,
	input  logic [FRAC_BITS:0]   a_mant,
	input  logic                 b_sign,
	input  logic [EXP_WIDTH-1:0] b_exp,
	input  logic [FRAC_BITS:0]   b_mant,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 res_sign,
	output logic [EXP_WIDTH-1:0] res_exp,
	output logic [FRAC_BITS:0]   res_mant,
	output logic [1:0]           res_status
);

	localparam int MW = FRAC_BITS + 1;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	fasu_pkg::norm_ctrl_t norm_ctrl;

	assign adv5 = !v_s5 || !out_stall;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall  = !adv1;
	assign out_valid = v_s5;
	assign norm_ctrl = '{load_s4: adv4, load_s5: adv5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// stage 1: operand zero check, exponent compare, order by exponent
	logic                 b_sign_eff;
	logic                 a_zero, b_zero;
	logic                 a_gt;
	logic [EXP_WIDTH-1:0] exp_diff;

	logic                 pass_s1;
	logic                 sx_s1, sy_s1;
	logic [EXP_WIDTH-1:0] e_s1;
	logic [EXP_WIDTH-1:0] diff_s1;
	logic [MW-1:0]        x_s1, y_s1;

	always_comb begin
		b_sign_eff = req_type ? ((b_mant != '0) ? ~b_sign : 1'b0) : b_sign;
		a_zero     = (a_mant == '0);
		b_zero     = (b_mant == '0);
		a_gt       = (a_exp > b_exp);
		exp_diff   = a_gt ? (a_exp - b_exp) : (b_exp - a_exp);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pass_s1 <= a_zero || b_zero;
			diff_s1 <= exp_diff;
			// a zero operand passes the other one through in the x lane
			if (a_zero || (!b_zero && !a_gt)) begin
				sx_s1 <= b_sign_eff;
				e_s1  <= b_exp;
				x_s1  <= b_mant;
				sy_s1 <= a_sign;
				y_s1  <= a_mant;
			end else begin
				sx_s1 <= a_sign;
				e_s1  <= a_exp;
				x_s1  <= a_mant;
				sy_s1 <= b_sign_eff;
				y_s1  <= b_mant;
			end
		end
	end

	// stage 2: align the smaller operand, truncating
	logic                 pass_s2;
	logic                 sx_s2, sy_s2;
	logic [EXP_WIDTH-1:0] e_s2;
	logic [MW-1:0]        x_s2, y_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			pass_s2 <= pass_s1;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			e_s2    <= e_s1;
			x_s2    <= x_s1;
			y_s2    <= (int'(diff_s1) >= MW) ? '0 : (y_s1 >> diff_s1);
		end
	end

	// stage 3: pass x through for a zero operand; add on equal signs, larger minus smaller otherwise
	logic [MW:0]   sum;
	logic [MW-1:0] dxy, dyx;
	logic          x_ge_y;
	logic [MW:0]   m3_next;
	logic          s3_next;

	logic [MW:0]          m3_s3;
	logic [EXP_WIDTH-1:0] e_s3;
	logic                 sign_s3;
	logic                 pass_s3;
	logic                 sub_s3;

	always_comb begin
		sum    = {1'b0, x_s2} + {1'b0, y_s2};
		dxy    = x_s2 - y_s2;
		dyx    = y_s2 - x_s2;
		x_ge_y = (x_s2 >= y_s2);
		if (pass_s2 || (sx_s2 == sy_s2)) begin
			m3_next = pass_s2 ? {1'b0, x_s2} : sum;
			s3_next = sx_s2;
		end else if (x_ge_y) begin
			m3_next = {1'b0, dxy};
			s3_next = sx_s2;
		end else begin
			m3_next = {1'b0, dyx};
			s3_next = sy_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			m3_s3   <= m3_next;
			e_s3    <= e_s2;
			sign_s3 <= s3_next;
			pass_s3 <= pass_s2;
			sub_s3  <= !pass_s2 && (sx_s2 != sy_s2);
		end
	end

	// stages 4 and 5
	fasu_norm #(
		.EXP_WIDTH(EXP_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_norm (
		.clk       (clk),
		.ctrl      (norm_ctrl),
		.m3_s3     (m3_s3),
		.e3_s3     (e_s3),
		.sign_s3   (sign_s3),
		.pass_s3   (pass_s3),
		.sub_s3    (sub_s3),
		.res_sign  (res_sign),
		.res_exp   (res_exp),
		.res_mant  (res_mant),
		.res_status(res_status)
	);

	// an empty first stage never pushes back
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with an empty first stage");

	// an input transfer fills the first stage
	a_transfer_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("input transfer lost");

	// exponent flags come only with a normalized mantissa
	a_flag_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_status != fasu_pkg::ST_OK) |-> res_mant[FRAC_BITS])
		else $error("exponent flag on an unnormalized result");

	// overflow wraps the exponent to zero
	a_ovf_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_status == fasu_pkg::ST_OVF) |-> (res_exp == '0))
		else $error("overflow without exponent wrap");

endmodule
